@@ rtl/core/sfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types and codes for the stereo FIR convolution block.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int COEF_INDEX_BITS = 9;

    localparam logic CMD_COEF  = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_HOLD
    } state_t;

    // sequencer to mac unit
    typedef struct packed {
        logic start;
        logic valid;
        logic last;
    } mac_ctrl_t;

    // mac unit to sequencer
    typedef struct packed {
        logic done;
        logic clip;
    } mac_stat_t;

endpackage

@@ rtl/core/sfc_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_store
// Left/right sample history and tap table, one write and one registered read
// port each.
// ----------------------------------------------------------------------------
module sfc_store #(
    parameter int TAPS        = 512,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16,
    localparam int ADDR_W     = $clog2(TAPS)
) (
    input  logic                          aclk,
    input  logic                          hist_we,
    input  logic [ADDR_W-1:0]             hist_waddr,
    input  logic signed [SAMPLE_BITS-1:0] left_wdata,
    input  logic signed [SAMPLE_BITS-1:0] right_wdata,
    input  logic                          tap_we,
    input  logic [ADDR_W-1:0]             tap_waddr,
    input  logic signed [COEF_BITS-1:0]   tap_wdata,
    input  logic [ADDR_W-1:0]             hist_raddr,
    input  logic [ADDR_W-1:0]             tap_raddr,
    output logic signed [SAMPLE_BITS-1:0] left_rdata,
    output logic signed [SAMPLE_BITS-1:0] right_rdata,
    output logic signed [COEF_BITS-1:0]   tap_rdata
);

    logic signed [SAMPLE_BITS-1:0] left_mem  [TAPS];
    logic signed [SAMPLE_BITS-1:0] right_mem [TAPS];
    logic signed [COEF_BITS-1:0]   tap_mem   [TAPS];

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            left_mem[hist_waddr]  <= left_wdata;
            right_mem[hist_waddr] <= right_wdata;
        end
        left_rdata  <= left_mem[hist_raddr];
        right_rdata <= right_mem[hist_raddr];
    end

    always_ff @(posedge aclk) begin
        if (tap_we) begin
            tap_mem[tap_waddr] <= tap_wdata;
        end
        tap_rdata <= tap_mem[tap_raddr];
    end

endmodule

@@ rtl/core/sfc_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_mac
// Shared stereo multiply-accumulate unit with round half up and saturation
// to the sample width.
// ----------------------------------------------------------------------------
module sfc_mac #(
    parameter int TAPS        = 512,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sfc_pkg::mac_ctrl_t            ctrl,
    input  logic signed [SAMPLE_BITS-1:0] left_smp,
    input  logic signed [SAMPLE_BITS-1:0] right_smp,
    input  logic signed [COEF_BITS-1:0]   coef,
    output sfc_pkg::mac_stat_t            stat,
    output logic signed [SAMPLE_BITS-1:0] left_res,
    output logic signed [SAMPLE_BITS-1:0] right_res
);

    import sfc_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);

    localparam logic signed [ACC_W:0] RND =
        {{(ACC_W + 2 - COEF_BITS){1'b0}}, 1'b1, {(COEF_BITS - 2){1'b0}}};
    localparam logic signed [ACC_W:0] SAT_HI =
        {{(ACC_W + 2 - SAMPLE_BITS){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W:0] SAT_LO = ~SAT_HI;

    logic                       v1_reg, l1_reg, v2_reg, l2_reg, fin_reg, done_reg;
    logic signed [PROD_W-1:0]   lprod_reg, rprod_reg;
    logic signed [ACC_W-1:0]    lacc_reg, racc_reg;
    logic signed [SAMPLE_BITS-1:0] lres_reg, rres_reg;
    logic                       clip_reg;

    logic signed [ACC_W:0]      lsum, rsum, lsh, rsh;
    logic signed [SAMPLE_BITS-1:0] lsat, rsat;
    logic                       lclip, rclip;

    // pipeline control: read data, product, accumulate, finish
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            l1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            l2_reg   <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= ctrl.valid;
            l1_reg   <= ctrl.valid & ctrl.last;
            v2_reg   <= v1_reg;
            l2_reg   <= l1_reg;
            fin_reg  <= l2_reg;
            done_reg <= fin_reg;
        end
    end

    always_ff @(posedge aclk) begin
        lprod_reg <= left_smp * coef;
        rprod_reg <= right_smp * coef;
        if (ctrl.start) begin
            lacc_reg <= '0;
            racc_reg <= '0;
        end else if (v2_reg) begin
            lacc_reg <= lacc_reg + ACC_W'(lprod_reg);
            racc_reg <= racc_reg + ACC_W'(rprod_reg);
        end
        if (fin_reg) begin
            lres_reg <= lsat;
            rres_reg <= rsat;
            clip_reg <= lclip | rclip;
        end
    end

    always_comb begin
        lsum  = (ACC_W + 1)'(lacc_reg) + RND;
        rsum  = (ACC_W + 1)'(racc_reg) + RND;
        lsh   = lsum >>> (COEF_BITS - 1);
        rsh   = rsum >>> (COEF_BITS - 1);
        lclip = (lsh > SAT_HI) || (lsh < SAT_LO);
        rclip = (rsh > SAT_HI) || (rsh < SAT_LO);
        if (lsh > SAT_HI) begin
            lsat = SAT_HI[SAMPLE_BITS-1:0];
        end else if (lsh < SAT_LO) begin
            lsat = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            lsat = lsh[SAMPLE_BITS-1:0];
        end
        if (rsh > SAT_HI) begin
            rsat = SAT_HI[SAMPLE_BITS-1:0];
        end else if (rsh < SAT_LO) begin
            rsat = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            rsat = rsh[SAMPLE_BITS-1:0];
        end
    end

    assign stat.done = done_reg;
    assign stat.clip = clip_reg;
    assign left_res  = lres_reg;
    assign right_res = rres_reg;

endmodule

@@ rtl/core/stereo_fir_convolution.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_fir_convolution
// Stereo direct-form FIR with one shared impulse response and loadable taps.
// ----------------------------------------------------------------------------
// Results pass the read, product, accumulate, finish and done registers to
// the output register, held while the output stalls. The single stereo mac
// unit takes one tap per cycle; a frame is taken only after the last result
// is loaded. Coefficient writes give no result. Reset: synchronous active-low
// aresetn, then a clearing pass zeroes history and taps while s_ready is low.
module stereo_fir_convolution #(
    parameter int TAPS        = 512,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_cmd,
    input  logic [sfc_pkg::COEF_INDEX_BITS-1:0]  s_coef_index,
    input  logic signed [COEF_BITS-1:0]          s_coef_value,
    input  logic signed [SAMPLE_BITS-1:0]        s_left_in,
    input  logic signed [SAMPLE_BITS-1:0]        s_right_in,
    input  logic                                 s_chunk_end,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [SAMPLE_BITS-1:0]        m_left_out,
    output logic signed [SAMPLE_BITS-1:0]        m_right_out,
    output logic                                 m_frame_last,
    output logic                                 m_clipped
);

    import sfc_pkg::*;

    localparam int ADDR_W = $clog2(TAPS);
    localparam logic [ADDR_W-1:0] ADDR_TOP = ADDR_W'(TAPS - 1);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [ADDR_W-1:0]   wp_reg, wp_next;
    logic [ADDR_W-1:0]   rd_reg, rd_next;
    logic [ADDR_W-1:0]   past_reg, past_next;
    logic                last_reg, last_next;
    logic                m_valid_reg, m_valid_next;
    logic signed [SAMPLE_BITS-1:0] m_left_reg, m_right_reg;
    logic                m_last_reg, m_clip_reg;

    logic                accept, frame_acc, coef_acc, out_free, load_out;
    logic [ADDR_W-1:0]   wp_inc, rd_dec;
    mac_ctrl_t           mac_ctrl;
    mac_stat_t           mac_stat;

    logic                hist_we, tap_we;
    logic [ADDR_W-1:0]   hist_waddr, tap_waddr;
    logic signed [SAMPLE_BITS-1:0] left_wdata, right_wdata, left_rd, right_rd;
    logic signed [SAMPLE_BITS-1:0] left_res, right_res;
    logic signed [COEF_BITS-1:0]   tap_wdata, tap_rd;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign frame_acc = accept && (s_cmd == CMD_FRAME);
    assign coef_acc  = accept && (s_cmd == CMD_COEF) && (32'(s_coef_index) < TAPS);
    assign out_free  = !m_valid_reg || m_ready;

    assign wp_inc = (wp_reg == ADDR_TOP) ? '0 : wp_reg + 1'b1;
    assign rd_dec = (rd_reg == '0) ? ADDR_TOP : rd_reg - 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            wp_reg      <= '0;
            rd_reg      <= '0;
            past_reg    <= '0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            wp_reg      <= wp_next;
            rd_reg      <= rd_next;
            past_reg    <= past_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_left_reg  <= left_res;
            m_right_reg <= right_res;
            m_last_reg  <= last_reg;
            m_clip_reg  <= mac_stat.clip;
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        wp_next        = wp_reg;
        rd_next        = rd_reg;
        past_next      = past_reg;
        last_next      = last_reg;
        load_out       = 1'b0;
        mac_ctrl.start = 1'b0;
        mac_ctrl.valid = 1'b0;
        mac_ctrl.last  = 1'b0;
        hist_we        = 1'b0;
        hist_waddr     = wp_inc;
        left_wdata     = s_left_in;
        right_wdata    = s_right_in;
        tap_we         = coef_acc;
        tap_waddr      = ADDR_W'(s_coef_index);
        tap_wdata      = s_coef_value;

        case (state_reg)
            ST_CLEAR: begin
                hist_we     = 1'b1;
                hist_waddr  = clr_reg;
                left_wdata  = '0;
                right_wdata = '0;
                tap_we      = 1'b1;
                tap_waddr   = clr_reg;
                tap_wdata   = '0;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == ADDR_TOP) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (frame_acc) begin
                    hist_we        = 1'b1;
                    wp_next        = wp_inc;
                    rd_next        = wp_inc;
                    past_next      = '0;
                    last_next      = s_chunk_end;
                    mac_ctrl.start = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            ST_RUN: begin
                // one tap per cycle, newest sample against tap zero first
                mac_ctrl.valid = 1'b1;
                mac_ctrl.last  = (past_reg == ADDR_TOP);
                past_next      = past_reg + 1'b1;
                rd_next        = rd_dec;
                if (past_reg == ADDR_TOP) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (mac_stat.done) begin
                    if (out_free) begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    sfc_store #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_store (
        .aclk        (aclk),
        .hist_we     (hist_we),
        .hist_waddr  (hist_waddr),
        .left_wdata  (left_wdata),
        .right_wdata (right_wdata),
        .tap_we      (tap_we),
        .tap_waddr   (tap_waddr),
        .tap_wdata   (tap_wdata),
        .hist_raddr  (rd_reg),
        .tap_raddr   (past_reg),
        .left_rdata  (left_rd),
        .right_rdata (right_rd),
        .tap_rdata   (tap_rd)
    );

    sfc_mac #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (mac_ctrl),
        .left_smp    (left_rd),
        .right_smp   (right_rd),
        .coef        (tap_rd),
        .stat        (mac_stat),
        .left_res    (left_res),
        .right_res   (right_res)
    );

    assign m_valid      = m_valid_reg;
    assign m_left_out   = m_left_reg;
    assign m_right_out  = m_right_reg;
    assign m_frame_last = m_last_reg;
    assign m_clipped    = m_clip_reg;

    // the mac result only shows up while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        mac_stat.done |-> (state_reg == ST_WAIT))
        else $error("mac done outside of wait state");

    // an accepted frame starts the tap sweep at tap zero on the new position
    assert property (@(posedge aclk) disable iff (!aresetn)
        frame_acc |=> (state_reg == ST_RUN) && (past_reg == '0) && (rd_reg == wp_reg))
        else $error("tap sweep did not start correctly");

    // a new result is loaded only when the computation finished
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past((state_reg == ST_WAIT) || (state_reg == ST_HOLD)))
        else $error("result transaction raised without a finished frame");

    // the sweep ends on the last tap and hands over to the drain state
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_RUN) && (past_reg == ADDR_TOP)) |=> (state_reg == ST_WAIT))
        else $error("tap sweep overran");

endmodule
